### rtl/mftt_pkg.sv
package mftt_pkg;

   // sizing of the count tables
   localparam int WORD_COUNT = 256;
   localparam int TAG_COUNT  = 32;
   localparam int COUNT_BITS = 16;

   // fixed field widths
   localparam int OP_BITS      = 2;
   localparam int WORD_ID_BITS = 8;
   localparam int TAG_ID_BITS  = 5;
   localparam int THR_BITS     = 16;

   localparam int WORD_BITS  = $clog2(WORD_COUNT);
   localparam int TAG_BITS   = $clog2(TAG_COUNT);
   localparam int PAIR_BITS  = WORD_BITS + TAG_BITS;
   localparam int PAIR_DEPTH = WORD_COUNT * (2 ** TAG_BITS);
   localparam int VOTE_BITS  = $clog2(WORD_COUNT + 1);
   localparam int BEST_BITS  = COUNT_BITS + TAG_BITS;

   localparam int MAG_A    = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;
   localparam int MAG_BITS = (MAG_A > VOTE_BITS) ? MAG_A : VOTE_BITS;
   // extra low bits carry the inverted tag for the tie-break compare
   localparam int UNIT_W   = MAG_BITS + TAG_BITS;

   localparam logic [UNIT_W-1:0] COUNT_MAX = UNIT_W'((64'd1 << COUNT_BITS) - 64'd1);

   localparam logic [OP_BITS-1:0] OP_ADD     = 2'd0;
   localparam logic [OP_BITS-1:0] OP_LOOKUP  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_UNKNOWN = 2'd2;

   typedef struct packed {
      logic [UNIT_W-1:0] a;
      logic [UNIT_W-1:0] b;
      logic              sat;
   } alu_req_type;

   typedef struct packed {
      logic              gt;
      logic [UNIT_W-1:0] inc;
   } alu_rsp_type;

endpackage

### rtl/mftt_ram.sv
module mftt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/mftt_alu.sv
module mftt_alu
   import mftt_pkg::*;
(
   input  alu_req_type alu_req,
   output alu_rsp_type alu_rsp
);

   always_comb begin
      alu_rsp.gt = (alu_req.a > alu_req.b);
      if (alu_req.sat && (alu_req.a == COUNT_MAX)) begin
         alu_rsp.inc = alu_req.a;
      end else begin
         alu_rsp.inc = alu_req.a + UNIT_W'(1);
      end
   end

endmodule

### rtl/most_frequent_tag_trainer.sv
// Most-frequent-tag trainer. Requests carry an operation in req_tuser (add a
// word/tag sample, look up a word, or pick the tag for unknown words) and the
// word and tag ids in req_tdata; lookups and unknown-tag requests return one
// response, adds return none. After reset the block sweeps the pair-count
// memory once, one entry per cycle, clearing the best-tag table as well,
// before req_tready first rises; the threshold register may be written
// meanwhile. An add reads the pair count and best entry, increments the
// count, writes it back and may update the best entry; a lookup reads the
// best entry and compares it with the threshold. An unknown-tag request
// clears the vote table, scans every word for its vote and searches the
// votes for the winning tag. Every step uses the single read port of each
// table and one shared compare/increment unit. A finished response waits in
// an output register, so the next request is taken while it is pending.
module most_frequent_tag_trainer
   import mftt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,  // word_id [7:0], tag_id [12:8], zero [15:13]
   input  logic [OP_BITS-1:0]  req_tuser,  // operation [1:0]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,  // tag [4:0], zero [7:5]
   output logic [1:0]          rsp_tuser,  // known [0], seen [1]
   input  logic                csr_wr_en,
   input  logic [THR_BITS-1:0] csr_wr_data
);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_ADD_RD, ST_ADD_INC, ST_ADD_UPD, ST_LK_RD, ST_LK_CHK,
      ST_VCLR, ST_SCAN_RD, ST_SCAN_CHK, ST_SCAN_INC, ST_MAX_RD, ST_MAX_CHK, ST_RESP
   } state_type;

   state_type                state_ff, state_in;
   logic [PAIR_BITS-1:0]     ctr_ff, ctr_in;
   logic [WORD_BITS-1:0]     word_ff, word_in;
   logic [TAG_BITS-1:0]      tag_ff, tag_in;
   logic                     word_ok_ff, word_ok_in;
   logic [COUNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                     found_ff, found_in;
   logic [TAG_BITS-1:0]      win_ff, win_in;
   logic [VOTE_BITS-1:0]     win_votes_ff, win_votes_in;
   logic [THR_BITS-1:0]      thr_ff, thr_in;
   logic [TAG_BITS-1:0]      first_tag_ff, first_tag_in;
   logic                     any_ff, any_in;
   logic [TAG_ID_BITS-1:0]   res_tag_ff, res_tag_in;
   logic                     res_known_ff, res_known_in;
   logic                     res_seen_ff, res_seen_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [TAG_ID_BITS-1:0]   rsp_tag_ff, rsp_tag_in;
   logic                     rsp_known_ff, rsp_known_in;
   logic                     rsp_seen_ff, rsp_seen_in;

   logic [WORD_ID_BITS-1:0]  req_word;
   logic [TAG_ID_BITS-1:0]   req_tag;
   logic                     req_word_ok;
   logic                     req_tag_ok;

   logic                     pair_wr_en, pair_rd_en;
   logic [PAIR_BITS-1:0]     pair_wr_addr, pair_rd_addr;
   logic [COUNT_BITS-1:0]    pair_wr_data, pair_rd_data;
   logic                     best_wr_en, best_rd_en;
   logic [WORD_BITS-1:0]     best_wr_addr, best_rd_addr;
   logic [BEST_BITS-1:0]     best_wr_data, best_rd_data;
   logic                     vote_wr_en, vote_rd_en;
   logic [TAG_BITS-1:0]      vote_wr_addr, vote_rd_addr;
   logic [VOTE_BITS-1:0]     vote_wr_data, vote_rd_data;

   logic [COUNT_BITS-1:0]    best_cnt;
   logic [TAG_BITS-1:0]      best_tag;
   logic [WORD_BITS-1:0]     ctr_word;
   logic [TAG_BITS-1:0]      ctr_tag;

   alu_req_type              alu_req;
   alu_rsp_type              alu_rsp;

   mftt_ram #(.WIDTH(COUNT_BITS), .DEPTH(PAIR_DEPTH)) u_pair_ram (
      .clock   (clock),
      .wr_en   (pair_wr_en),
      .wr_addr (pair_wr_addr),
      .wr_data (pair_wr_data),
      .rd_en   (pair_rd_en),
      .rd_addr (pair_rd_addr),
      .rd_data (pair_rd_data)
   );

   mftt_ram #(.WIDTH(BEST_BITS), .DEPTH(WORD_COUNT)) u_best_ram (
      .clock   (clock),
      .wr_en   (best_wr_en),
      .wr_addr (best_wr_addr),
      .wr_data (best_wr_data),
      .rd_en   (best_rd_en),
      .rd_addr (best_rd_addr),
      .rd_data (best_rd_data)
   );

   mftt_ram #(.WIDTH(VOTE_BITS), .DEPTH(TAG_COUNT)) u_vote_ram (
      .clock   (clock),
      .wr_en   (vote_wr_en),
      .wr_addr (vote_wr_addr),
      .wr_data (vote_wr_data),
      .rd_en   (vote_rd_en),
      .rd_addr (vote_rd_addr),
      .rd_data (vote_rd_data)
   );

   mftt_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign req_word    = req_tdata[7:0];
   assign req_tag     = req_tdata[12:8];
   assign req_word_ok = (32'(req_word) < WORD_COUNT);
   assign req_tag_ok  = (32'(req_tag) < TAG_COUNT);

   assign best_cnt = best_rd_data[BEST_BITS-1:TAG_BITS];
   assign best_tag = best_rd_data[TAG_BITS-1:0];
   assign ctr_word = ctr_ff[WORD_BITS-1:0];
   assign ctr_tag  = ctr_ff[TAG_BITS-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 8'(rsp_tag_ff);
   assign rsp_tuser  = {rsp_seen_ff, rsp_known_ff};

   always_comb begin
      state_in     = state_ff;
      ctr_in       = ctr_ff;
      word_in      = word_ff;
      tag_in       = tag_ff;
      word_ok_in   = word_ok_ff;
      cnt_in       = cnt_ff;
      found_in     = found_ff;
      win_in       = win_ff;
      win_votes_in = win_votes_ff;
      thr_in       = thr_ff;
      first_tag_in = first_tag_ff;
      any_in       = any_ff;
      res_tag_in   = res_tag_ff;
      res_known_in = res_known_ff;
      res_seen_in  = res_seen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_tag_in   = rsp_tag_ff;
      rsp_known_in = rsp_known_ff;
      rsp_seen_in  = rsp_seen_ff;

      pair_wr_en   = 1'b0;
      pair_wr_addr = {word_ff, tag_ff};
      pair_wr_data = cnt_ff;
      pair_rd_en   = 1'b0;
      pair_rd_addr = {word_ff, tag_ff};
      best_wr_en   = 1'b0;
      best_wr_addr = word_ff;
      best_wr_data = {cnt_ff, tag_ff};
      best_rd_en   = 1'b0;
      best_rd_addr = word_ff;
      vote_wr_en   = 1'b0;
      vote_wr_addr = best_tag;
      vote_wr_data = alu_rsp.inc[VOTE_BITS-1:0];
      vote_rd_en   = 1'b0;
      vote_rd_addr = ctr_tag;

      alu_req.a   = '0;
      alu_req.b   = '0;
      alu_req.sat = 1'b0;

      if (csr_wr_en) begin
         thr_in = csr_wr_data;
      end

      case (state_ff)
         ST_CLEAR: begin
            pair_wr_en   = 1'b1;
            pair_wr_addr = ctr_ff;
            pair_wr_data = '0;
            best_wr_en   = (ctr_ff < PAIR_BITS'(WORD_COUNT));
            best_wr_addr = ctr_word;
            best_wr_data = '0;
            if (ctr_ff == PAIR_BITS'(PAIR_DEPTH - 1)) begin
               ctr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ctr_in = ctr_ff + PAIR_BITS'(1);
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               word_in    = WORD_BITS'(req_word);
               tag_in     = TAG_BITS'(req_tag);
               word_ok_in = req_word_ok;
               case (req_tuser)
                  OP_ADD: begin
                     if (req_word_ok && req_tag_ok) begin
                        state_in = ST_ADD_RD;
                     end
                  end
                  OP_LOOKUP: begin
                     state_in = ST_LK_RD;
                  end
                  OP_UNKNOWN: begin
                     ctr_in       = '0;
                     found_in     = 1'b0;
                     win_in       = '0;
                     win_votes_in = '0;
                     state_in     = ST_VCLR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADD_RD: begin
            pair_rd_en = 1'b1;
            best_rd_en = 1'b1;
            state_in   = ST_ADD_INC;
         end
         ST_ADD_INC: begin
            alu_req.a   = UNIT_W'(pair_rd_data);
            alu_req.sat = 1'b1;
            cnt_in      = alu_rsp.inc[COUNT_BITS-1:0];
            state_in    = ST_ADD_UPD;
         end
         ST_ADD_UPD: begin
            // inverted tag in the low bits: equal counts favor the lower tag
            alu_req.a  = UNIT_W'({cnt_ff, ~tag_ff});
            alu_req.b  = UNIT_W'({best_cnt, ~best_tag});
            pair_wr_en = 1'b1;
            best_wr_en = alu_rsp.gt;
            if (!any_ff) begin
               any_in       = 1'b1;
               first_tag_in = tag_ff;
            end
            state_in = ST_IDLE;
         end
         ST_LK_RD: begin
            best_rd_en = 1'b1;
            state_in   = ST_LK_CHK;
         end
         ST_LK_CHK: begin
            alu_req.a = UNIT_W'(best_cnt);
            alu_req.b = UNIT_W'(thr_ff);
            if (word_ok_ff && (best_cnt != '0)) begin
               res_tag_in   = TAG_ID_BITS'(best_tag);
               res_known_in = alu_rsp.gt;
               res_seen_in  = 1'b1;
            end else begin
               res_tag_in   = '0;
               res_known_in = 1'b0;
               res_seen_in  = 1'b0;
            end
            state_in = ST_RESP;
         end
         ST_VCLR: begin
            vote_wr_en   = 1'b1;
            vote_wr_addr = ctr_tag;
            vote_wr_data = '0;
            if (ctr_ff == PAIR_BITS'(TAG_COUNT - 1)) begin
               ctr_in   = '0;
               state_in = ST_SCAN_RD;
            end else begin
               ctr_in = ctr_ff + PAIR_BITS'(1);
            end
         end
         ST_SCAN_RD: begin
            best_rd_en   = 1'b1;
            best_rd_addr = ctr_word;
            state_in     = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            alu_req.a = UNIT_W'(best_cnt);
            alu_req.b = UNIT_W'(thr_ff);
            if ((best_cnt != '0) && !alu_rsp.gt) begin
               found_in     = 1'b1;
               vote_rd_en   = 1'b1;
               vote_rd_addr = best_tag;
               state_in     = ST_SCAN_INC;
            end else if (ctr_ff == PAIR_BITS'(WORD_COUNT - 1)) begin
               ctr_in   = '0;
               state_in = ST_MAX_RD;
            end else begin
               ctr_in   = ctr_ff + PAIR_BITS'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_INC: begin
            alu_req.a  = UNIT_W'(vote_rd_data);
            vote_wr_en = 1'b1;
            if (ctr_ff == PAIR_BITS'(WORD_COUNT - 1)) begin
               ctr_in   = '0;
               state_in = ST_MAX_RD;
            end else begin
               ctr_in   = ctr_ff + PAIR_BITS'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_MAX_RD: begin
            vote_rd_en = 1'b1;
            state_in   = ST_MAX_CHK;
         end
         ST_MAX_CHK: begin
            alu_req.a = UNIT_W'(vote_rd_data);
            alu_req.b = UNIT_W'(win_votes_ff);
            if (alu_rsp.gt) begin
               win_in       = ctr_tag;
               win_votes_in = vote_rd_data;
            end
            if (ctr_ff == PAIR_BITS'(TAG_COUNT - 1)) begin
               ctr_in       = '0;
               res_tag_in   = TAG_ID_BITS'(found_ff ? win_in : first_tag_ff);
               res_known_in = found_ff;
               res_seen_in  = any_ff;
               state_in     = ST_RESP;
            end else begin
               ctr_in   = ctr_ff + PAIR_BITS'(1);
               state_in = ST_MAX_RD;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_tag_in   = res_tag_ff;
               rsp_known_in = res_known_ff;
               rsp_seen_in  = res_seen_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ctr_ff       <= '0;
         thr_ff       <= '0;
         first_tag_ff <= '0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctr_ff       <= ctr_in;
         thr_ff       <= thr_in;
         first_tag_ff <= first_tag_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff      <= word_in;
      tag_ff       <= tag_in;
      word_ok_ff   <= word_ok_in;
      cnt_ff       <= cnt_in;
      found_ff     <= found_in;
      win_ff       <= win_in;
      win_votes_ff <= win_votes_in;
      res_tag_ff   <= res_tag_in;
      res_known_ff <= res_known_in;
      res_seen_ff  <= res_seen_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_known_ff <= rsp_known_in;
      rsp_seen_ff  <= rsp_seen_in;
   end

endmodule

### rtl/mftt_checker.sv
module mftt_props
   import mftt_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_tvalid,
   input logic               req_tready,
   input logic [OP_BITS-1:0] req_tuser,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [7:0]         rsp_tdata,
   input logic [1:0]         rsp_tuser
);

   // a pending response holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // reset starts the clearing sweep: nothing accepted, nothing shown
   assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("block active right after reset");

   // ready drops after a lookup is taken
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_LOOKUP) |=> !req_tready)
      else $error("ready right after lookup request");

   // an add raises no response when none was pending
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_ADD) && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response after add request");

   // known implies some sample was seen
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[1])
      else $error("known without seen");

endmodule

bind most_frequent_tag_trainer mftt_props u_mftt_props (.*);

### test/mftt_checker.sv
`timescale 1ns / 100ps
module mftt_checker
   import mftt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [15:0]         req_tdata,  // word_id [7:0], tag_id [12:8], zero [15:13]
   input  logic [OP_BITS-1:0]  req_tuser,  // operation [1:0]
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [7:0]          rsp_tdata,  // tag [4:0], zero [7:5]
   input  logic [1:0]          rsp_tuser,  // known [0], seen [1]
   input  logic                csr_wr_en,
   input  logic [THR_BITS-1:0] csr_wr_data,
   output int                  mismatch_count,
   output int                  pending_count,
   output int                  checked_count
);

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [TAG_ID_BITS-1:0] tag;
      logic                   known;
      logic                   seen;
   } tag_answer_t;

   logic [COUNT_BITS-1:0]  pair_tally [WORD_COUNT * TAG_COUNT];
   logic [TAG_ID_BITS-1:0] best_tag [WORD_COUNT];
   logic [COUNT_BITS-1:0]  best_tally [WORD_COUNT];
   logic [TAG_ID_BITS-1:0] first_tag;
   logic                   any_added;
   logic [THR_BITS-1:0]    threshold;
   tag_answer_t            tag_answers [$];

   function automatic void count_sample(logic [WORD_ID_BITS-1:0] word,
                                        logic [TAG_ID_BITS-1:0] tag);
      int unsigned          slot;
      logic [COUNT_BITS-1:0] tally;
      slot  = int'(word) * TAG_COUNT + int'(tag);
      tally = pair_tally[slot];
      if (tally != '1) tally = tally + 1'b1;
      pair_tally[slot] = tally;
      if (tally > best_tally[word]) begin
         best_tally[word] = tally;
         best_tag[word]   = tag;
      end else if (tally == best_tally[word] && tag < best_tag[word]) begin
         best_tag[word] = tag;
      end
      if (!any_added) begin
         any_added = 1'b1;
         first_tag = tag;
      end
   endfunction

   function automatic tag_answer_t word_answer(logic [WORD_ID_BITS-1:0] word);
      tag_answer_t ans;
      ans = '0;
      if (best_tally[word] != '0) begin
         ans.tag   = best_tag[word];
         ans.known = (THR_BITS'(best_tally[word]) > threshold);
         ans.seen  = 1'b1;
      end
      return ans;
   endfunction

   // every seen word at or below the threshold votes for its best tag
   function automatic tag_answer_t unknown_answer();
      tag_answer_t ans;
      int          votes [TAG_COUNT];
      int          top_votes;
      logic        found;
      found = 1'b0;
      top_votes = 0;
      foreach (votes[t]) votes[t] = 0;
      ans = '0;
      for (int w = 0; w < WORD_COUNT; w++) begin
         if (best_tally[w] != '0 && THR_BITS'(best_tally[w]) <= threshold) begin
            votes[best_tag[w]]++;
            found = 1'b1;
         end
      end
      if (found) begin
         for (int t = 0; t < TAG_COUNT; t++) begin
            if (votes[t] > top_votes) begin
               top_votes = votes[t];
               ans.tag   = TAG_ID_BITS'(t);
            end
         end
      end else begin
         ans.tag = first_tag;
      end
      ans.known = found;
      ans.seen  = any_added;
      return ans;
   endfunction

   always @(posedge clock) begin
      tag_answer_t want;
      if (reset) begin
         foreach (pair_tally[i]) pair_tally[i] = '0;
         foreach (best_tag[i]) best_tag[i] = '0;
         foreach (best_tally[i]) best_tally[i] = '0;
         first_tag = '0;
         any_added = 1'b0;
         threshold = '0;
         tag_answers.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            checked_count++;
            if (tag_answers.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: response with nothing outstanding: tdata %h tuser %b",
                           $realtime, rsp_tdata, rsp_tuser);
            end else begin
               want = tag_answers.pop_front();
               if (rsp_tdata !== 8'(want.tag) || rsp_tuser !== {want.seen, want.known}) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("%0t: response %0d expected tag %0d known %b seen %b, got %s",
                              $realtime, checked_count, want.tag, want.known, want.seen,
                              $sformatf("tdata %h known %b seen %b",
                                        rsp_tdata, rsp_tuser[0], rsp_tuser[1]));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               OP_ADD:     count_sample(req_tdata[7:0], req_tdata[12:8]);
               OP_LOOKUP:  tag_answers.push_back(word_answer(req_tdata[7:0]));
               OP_UNKNOWN: tag_answers.push_back(unknown_answer());
               default: ;
            endcase
         end
         if (csr_wr_en) threshold = csr_wr_data;
      end
      pending_count = tag_answers.size();
   end

endmodule

### test/most_frequent_tag_trainer_test.sv
`timescale 1ns / 100ps
module most_frequent_tag_trainer_test;
   import mftt_pkg::*;

   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_REQUESTS = 110;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [15:0]         req_tdata = '0;
   logic [OP_BITS-1:0]  req_tuser = OP_ADD;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [7:0]          rsp_tdata;
   logic [1:0]          rsp_tuser;
   logic                csr_wr_en = 1'b0;
   logic [THR_BITS-1:0] csr_wr_data = '0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int mismatch_count;
   int pending_count;
   int checked_count;
   int op_totals [4];
   int threshold_writes = 0;
   int quiet_cycles = 0;

   most_frequent_tag_trainer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   mftt_checker tally_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= rsp_stall_pct);
   end

   // reset sweep and unknown-tag scans are the longest legal quiet stretches
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send(input logic [OP_BITS-1:0] op, input int word, input int tag);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {3'b000, TAG_ID_BITS'(tag), WORD_ID_BITS'(word)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      op_totals[op]++;
      @(negedge clock);
   endtask

   task automatic send_random();
      int                 pick;
      int                 word;
      int                 tag;
      logic [OP_BITS-1:0] op;
      pick = $urandom_range(99);
      // a small word/tag pool builds up counts and ties; the rest spans the ranges
      word = ($urandom_range(9) < 7) ? $urandom_range(15) : $urandom_range(255);
      tag  = ($urandom_range(9) < 6) ? $urandom_range(3) : $urandom_range(31);
      if (pick < 62)
         op = OP_ADD;
      else if (pick < 88)
         op = OP_LOOKUP;
      else if (pick < 95)
         op = OP_UNKNOWN;
      else
         op = OP_UNUSED;
      send(op, word, tag);
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      // a trailing add may still be in flight
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_threshold(input int unsigned value);
      drain();
      csr_wr_en   = 1'b1;
      csr_wr_data = THR_BITS'(value);
      @(negedge clock);
      csr_wr_en = 1'b0;
      threshold_writes++;
   endtask

   initial begin
      int unsigned phase_thresholds [RANDOM_PHASES];
      phase_thresholds = '{0, 3, 65535, 1, 8, 2, 0, 5};
      phase_thresholds[4] = $urandom_range(40);
      phase_thresholds[6] = $urandom_range(12);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty tables, unused op, first sample at the field maxima
      send(OP_UNKNOWN, 0, 0);
      send(OP_LOOKUP, 0, 0);
      send(OP_UNUSED, 17, 9);
      send(OP_ADD, 255, 31);
      send(OP_UNKNOWN, 0, 0);
      send(OP_LOOKUP, 255, 0);
      // best tag moves to 5, then back to 0 on an equal count
      send(OP_ADD, 0, 0);
      send(OP_ADD, 0, 5);
      send(OP_ADD, 0, 5);
      send(OP_LOOKUP, 0, 0);
      send(OP_ADD, 0, 0);
      send(OP_LOOKUP, 0, 0);
      set_threshold(65535);
      send(OP_UNKNOWN, 0, 0);
      send(OP_LOOKUP, 0, 0);
      set_threshold(1);
      send(OP_UNKNOWN, 0, 0);
      send(OP_LOOKUP, 255, 0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_threshold(phase_thresholds[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 52; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 52; end
            default: begin send_idle_pct = 12; rsp_stall_pct = 12; end
         endcase
         repeat (PHASE_REQUESTS) send_random();
      end

      drain();
      $display("Covered %0d adds, %0d lookups, %0d unknown-tag scans, %0d unused ops,",
               op_totals[OP_ADD], op_totals[OP_LOOKUP], op_totals[OP_UNKNOWN],
               op_totals[OP_UNUSED]);
      $display("%0d threshold writes, %0d responses checked, %0d mismatches.",
               threshold_writes, checked_count, mismatch_count);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

### most_frequent_tag_trainer.f
rtl/mftt_pkg.sv
rtl/mftt_ram.sv
rtl/mftt_alu.sv
rtl/most_frequent_tag_trainer.sv
rtl/mftt_checker.sv
test/mftt_checker.sv
test/most_frequent_tag_trainer_test.sv
